>>> sv/lsfc_pkg.sv
// ----------------------------------------------------------------------------
// lsfc_pkg: shared types and constants for the log sample format classifier
// Item layouts, mode and register codes, verdict codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfc_pkg;

   // default sizes
   localparam int DEPTH_BITS_DEF      = 8;
   localparam int LINE_COUNT_BITS_DEF = 16;
   localparam int BYTE_COUNT_BITS_DEF = 24;

   // item modes
   localparam logic [1:0] MODE_BYTE   = 2'd0;
   localparam logic [1:0] MODE_EOL    = 2'd1;
   localparam logic [1:0] MODE_EOS    = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // verdict codes
   localparam logic [1:0] FMT_UNKNOWN = 2'd0;
   localparam logic [1:0] FMT_PLAIN   = 2'd1;
   localparam logic [1:0] FMT_JSON    = 2'd2;

   // register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINARY_DENSITY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_JSON_SHARE     = 2'd1;

   localparam logic [CSR_DATA_W-1:0] BINARY_DENSITY_RESET = 8'd10;
   localparam logic [CSR_DATA_W-1:0] JSON_SHARE_RESET     = 8'd2;

   // byte classes
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_DEL      = 8'h7F;
   localparam logic [7:0] CHAR_NUL      = 8'h00;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_BSLASH   = 8'h5C;
   localparam logic [7:0] CHAR_OPEN     = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE    = 8'h7D;

   localparam int SAMPLED_LINES_W = 16;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]                 format_code;
      logic                       looks_binary;
      logic [SAMPLED_LINES_W-1:0] sampled_lines;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> sv/log_sample_format_classifier_core.sv
// ----------------------------------------------------------------------------
// log_sample_format_classifier_core: log sample format classifier
// Judges a sample of log lines as binary, plain text or JSON lines.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: queue-style input. An item (mode, data_byte) is taken when req_push
//     is high and req_full is low. Mode 0 carries a line byte, mode 1 closes
//     a line, mode 2 closes the sample, mode 3 is dropped.
//   rsp_*: queue-style output. One result per end-of-sample item; it sits on
//     rsp_data while rsp_empty is low and leaves when rsp_pop is high.
//   csr_*: write-only factor registers; the user writes them only while the
//     block is idle, as the block itself has no check for it.
// Throughput: one item per cycle while req_full is low; the front updates all
//   line and sample state as each byte is taken.
// Path: an end-of-sample item enters the snapshot queue when taken, then
//   passes the multiply stage and then the compare stage.
// Reset: clears all line and sample state, empties the queues and restores
//   the factors to 10 and 2.
// Stall: results wait in the output stage and the multiply stage; the
//   two-entry snapshot queue fills next, and only then does req_full rise.
// ----------------------------------------------------------------------------
`default_nettype none

module log_sample_format_classifier_core
   import lsfc_pkg::*;
#(
   parameter int DEPTH_BITS      = DEPTH_BITS_DEF,
   parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF,
   parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   input  wire req_item_type           req_data,
   output logic                        req_full,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output rsp_item_type                rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int SNAP_W = 3 * LINE_COUNT_BITS + 2 * BYTE_COUNT_BITS + 1;

   logic              accept;
   logic              snap_push, snap_pop;
   logic              q_full, q_empty;
   logic [SNAP_W-1:0] snap_in, snap_out;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   lsfc_front #(
      .DEPTH_BITS      (DEPTH_BITS),
      .LINE_COUNT_BITS (LINE_COUNT_BITS),
      .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_data),
      .snap_push (snap_push),
      .snap_data (snap_in)
   );

   lsfc_fifo #(
      .WIDTH (SNAP_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (snap_push),
      .push_data (snap_in),
      .full      (q_full),
      .pop       (snap_pop),
      .empty     (q_empty),
      .pop_data  (snap_out)
   );

   lsfc_back #(
      .LINE_COUNT_BITS (LINE_COUNT_BITS),
      .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .snap_empty     (q_empty),
      .snap_data      (snap_out),
      .snap_pop       (snap_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data)
   );

   // nothing is left over from before reset
   a_reset_empty: assert property (@(posedge clock) (!reset && $past(reset)) |-> rsp_empty)
      else $error("result pending right after reset");

   // an end-of-sample item always lands in the snapshot queue
   a_eos_queued: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode == MODE_EOS) |=> !q_empty)
      else $error("end-of-sample item lost");

   // only an accepted end-of-sample item enqueues a snapshot
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      snap_push |-> (accept && req_data.mode == MODE_EOS))
      else $error("snapshot pushed without end-of-sample item");

   // a result appears only after a snapshot was waiting in the queue
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> !$past(q_empty, 2))
      else $error("result without a queued snapshot");

endmodule

`default_nettype wire

>>> sv/lsfc_fifo.sv
// ----------------------------------------------------------------------------
// lsfc_fifo: two-entry queue between front and back
// Register based; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfc_fifo
   import lsfc_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/lsfc_front.sv
// ----------------------------------------------------------------------------
// lsfc_front: per-byte line tracking and sample counters
// Updates line and sample state once per item; an end-of-sample item emits a
// snapshot of the sample counters and clears all state.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfc_front
   import lsfc_pkg::*;
#(
   parameter int DEPTH_BITS      = DEPTH_BITS_DEF,
   parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF,
   parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF,
   localparam int SNAP_W = 3 * LINE_COUNT_BITS + 2 * BYTE_COUNT_BITS + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_item_type      item,
   output logic                   snap_push,
   output logic [SNAP_W-1:0]      snap_data
);

   typedef struct packed {
      logic [LINE_COUNT_BITS-1:0] line_count;
      logic [LINE_COUNT_BITS-1:0] nonblank_count;
      logic [LINE_COUNT_BITS-1:0] json_count;
      logic [BYTE_COUNT_BITS-1:0] byte_total;
      logic [BYTE_COUNT_BITS-1:0] control_count;
      logic                       nul_seen;
   } snap_type;

   logic [1:0]                 nonspace_ff, nonspace_in;
   logic                       first_open_ff, first_open_in;
   logic                       last_close_ff, last_close_in;
   logic [DEPTH_BITS-1:0]      depth_ff, depth_in;
   logic                       in_string_ff, in_string_in;
   logic                       escape_ff, escape_in;
   logic                       key_ff, key_in;
   logic                       rejected_ff, rejected_in;
   logic                       line_open_ff, line_open_in;
   logic [LINE_COUNT_BITS-1:0] lines_ff, lines_in;
   logic [LINE_COUNT_BITS-1:0] nonblank_ff, nonblank_in;
   logic [LINE_COUNT_BITS-1:0] json_ff, json_in;
   logic [BYTE_COUNT_BITS-1:0] bytes_ff, bytes_in;
   logic [BYTE_COUNT_BITS-1:0] control_ff, control_in;
   logic                       nul_ff, nul_in;

   // counters as they stand after closing the current line
   logic [LINE_COUNT_BITS-1:0] eol_lines, eol_nonblank, eol_json;
   logic [BYTE_COUNT_BITS-1:0] eol_bytes, byte_inc;
   logic                       json_line;
   logic                       is_space, is_control;
   logic [7:0]                 c;
   snap_type                   snap;

   assign c = item.data_byte;
   assign is_space   = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   assign is_control = ((c < CHAR_SPACE) && (c != CHAR_TAB) && (c != CHAR_LF)
                        && (c != CHAR_CR)) || (c == CHAR_DEL);

   assign json_line = (nonspace_ff == 2'd2) && first_open_ff && last_close_ff &&
                      !rejected_ff && (depth_ff == '0) && key_ff && !in_string_ff;

   always_comb begin
      byte_inc     = (bytes_ff != '1) ? bytes_ff + 1'b1 : bytes_ff;
      eol_bytes    = byte_inc;
      eol_lines    = (lines_ff != '1) ? lines_ff + 1'b1 : lines_ff;
      eol_nonblank = nonblank_ff;
      eol_json     = json_ff;
      if (nonspace_ff != 2'd0) begin
         if (nonblank_ff != '1) eol_nonblank = nonblank_ff + 1'b1;
         if (json_line && json_ff != '1) eol_json = json_ff + 1'b1;
      end
   end

   always_comb begin
      nonspace_in   = nonspace_ff;
      first_open_in = first_open_ff;
      last_close_in = last_close_ff;
      depth_in      = depth_ff;
      in_string_in  = in_string_ff;
      escape_in     = escape_ff;
      key_in        = key_ff;
      rejected_in   = rejected_ff;
      line_open_in  = line_open_ff;
      lines_in      = lines_ff;
      nonblank_in   = nonblank_ff;
      json_in       = json_ff;
      bytes_in      = bytes_ff;
      control_in    = control_ff;
      nul_in        = nul_ff;
      snap_push     = 1'b0;
      snap.line_count     = lines_ff;
      snap.nonblank_count = nonblank_ff;
      snap.json_count     = json_ff;
      snap.byte_total     = bytes_ff;
      snap.control_count  = control_ff;
      snap.nul_seen       = nul_ff;

      if (accept) begin
         unique case (item.mode)
            MODE_BYTE: begin
               line_open_in = 1'b1;
               bytes_in     = byte_inc;
               if (c == CHAR_NUL) nul_in = 1'b1;
               if (is_control && control_ff != '1) control_in = control_ff + 1'b1;
               if (!is_space) begin
                  if (nonspace_ff == 2'd0) first_open_in = (c == CHAR_OPEN);
                  if (nonspace_ff != 2'd2) nonspace_in = nonspace_ff + 2'd1;
                  last_close_in = (c == CHAR_CLOSE);
               end
               if (!rejected_ff) begin
                  if (in_string_ff) begin
                     if (escape_ff) begin
                        escape_in = 1'b0;
                     end else if (c == CHAR_BSLASH) begin
                        escape_in = 1'b1;
                     end else if (c == CHAR_QUOTE) begin
                        in_string_in = 1'b0;
                     end
                  end else if (c == CHAR_QUOTE) begin
                     in_string_in = 1'b1;
                     if (depth_ff == DEPTH_BITS'(1)) key_in = 1'b1;
                  end else if (c == CHAR_OPEN) begin
                     if (depth_ff == '1) rejected_in = 1'b1;
                     else depth_in = depth_ff + 1'b1;
                  end else if (c == CHAR_CLOSE) begin
                     if (depth_ff == '0) rejected_in = 1'b1;
                     else depth_in = depth_ff - 1'b1;
                  end
               end
            end
            MODE_EOL, MODE_EOS: begin
               if (item.mode == MODE_EOL) begin
                  bytes_in    = eol_bytes;
                  lines_in    = eol_lines;
                  nonblank_in = eol_nonblank;
                  json_in     = eol_json;
               end else begin
                  // an unclosed line is closed before the verdict
                  snap_push = 1'b1;
                  if (line_open_ff) begin
                     snap.line_count     = eol_lines;
                     snap.nonblank_count = eol_nonblank;
                     snap.json_count     = eol_json;
                     snap.byte_total     = eol_bytes;
                  end
                  lines_in    = '0;
                  nonblank_in = '0;
                  json_in     = '0;
                  bytes_in    = '0;
                  control_in  = '0;
                  nul_in      = 1'b0;
               end
               nonspace_in   = 2'd0;
               first_open_in = 1'b0;
               last_close_in = 1'b0;
               depth_in      = '0;
               in_string_in  = 1'b0;
               escape_in     = 1'b0;
               key_in        = 1'b0;
               rejected_in   = 1'b0;
               line_open_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign snap_data = snap;

   always_ff @(posedge clock) begin
      if (reset) begin
         nonspace_ff   <= 2'd0;
         first_open_ff <= 1'b0;
         last_close_ff <= 1'b0;
         depth_ff      <= '0;
         in_string_ff  <= 1'b0;
         escape_ff     <= 1'b0;
         key_ff        <= 1'b0;
         rejected_ff   <= 1'b0;
         line_open_ff  <= 1'b0;
         lines_ff      <= '0;
         nonblank_ff   <= '0;
         json_ff       <= '0;
         bytes_ff      <= '0;
         control_ff    <= '0;
         nul_ff        <= 1'b0;
      end else begin
         nonspace_ff   <= nonspace_in;
         first_open_ff <= first_open_in;
         last_close_ff <= last_close_in;
         depth_ff      <= depth_in;
         in_string_ff  <= in_string_in;
         escape_ff     <= escape_in;
         key_ff        <= key_in;
         rejected_ff   <= rejected_in;
         line_open_ff  <= line_open_in;
         lines_ff      <= lines_in;
         nonblank_ff   <= nonblank_in;
         json_ff       <= json_in;
         bytes_ff      <= bytes_in;
         control_ff    <= control_in;
         nul_ff        <= nul_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/lsfc_back.sv
// ----------------------------------------------------------------------------
// lsfc_back: verdict pipeline and factor registers
// Stage one scales the counts by the factors, stage two compares and holds
// the result until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfc_back
   import lsfc_pkg::*;
#(
   parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF,
   parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF,
   localparam int SNAP_W = 3 * LINE_COUNT_BITS + 2 * BYTE_COUNT_BITS + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                   snap_empty,
   input  wire logic [SNAP_W-1:0]      snap_data,
   output logic                        snap_pop,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output rsp_item_type                rsp_data
);

   localparam int PB_W = BYTE_COUNT_BITS + CSR_DATA_W;
   localparam int PJ_W = LINE_COUNT_BITS + CSR_DATA_W;

   typedef struct packed {
      logic [LINE_COUNT_BITS-1:0] line_count;
      logic [LINE_COUNT_BITS-1:0] nonblank_count;
      logic [LINE_COUNT_BITS-1:0] json_count;
      logic [BYTE_COUNT_BITS-1:0] byte_total;
      logic [BYTE_COUNT_BITS-1:0] control_count;
      logic                       nul_seen;
   } snap_type;

   snap_type snap;

   logic [CSR_DATA_W-1:0]      bin_factor_ff, bin_factor_in;
   logic [CSR_DATA_W-1:0]      json_factor_ff, json_factor_in;

   logic                       s1_valid_ff, s1_valid_in;
   logic [PB_W-1:0]            prod_bin_ff, prod_bin_in;
   logic [PJ_W-1:0]            prod_json_ff, prod_json_in;
   logic [BYTE_COUNT_BITS-1:0] s1_bytes_ff;
   logic [LINE_COUNT_BITS-1:0] s1_nonblank_ff;
   logic [LINE_COUNT_BITS-1:0] s1_lines_ff;
   logic                       s1_nul_ff;

   logic                       out_valid_ff, out_valid_in;
   rsp_item_type               out_data_ff, out_data_in;

   logic                       out_ready, s1_ready;
   logic                       binary;
   logic [SAMPLED_LINES_W-1:0] lines_sat;

   assign snap      = snap_data;
   assign out_ready = !out_valid_ff || rsp_pop;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign snap_pop  = !snap_empty && s1_ready;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      bin_factor_in  = bin_factor_ff;
      json_factor_in = json_factor_ff;
      if (csr_write_en) begin
         if (csr_index == CSR_BINARY_DENSITY) bin_factor_in = csr_write_data;
         if (csr_index == CSR_JSON_SHARE)     json_factor_in = csr_write_data;
      end
   end

   assign prod_bin_in  = PB_W'(snap.control_count) * PB_W'(bin_factor_ff);
   assign prod_json_in = PJ_W'(snap.json_count) * PJ_W'(json_factor_ff);

   generate
      if (LINE_COUNT_BITS > SAMPLED_LINES_W) begin : g_sat
         assign lines_sat = (s1_lines_ff[LINE_COUNT_BITS-1:SAMPLED_LINES_W] != '0) ?
                            '1 : s1_lines_ff[SAMPLED_LINES_W-1:0];
      end else begin : g_ext
         assign lines_sat = SAMPLED_LINES_W'(s1_lines_ff);
      end
   endgenerate

   always_comb begin
      binary = s1_nul_ff ||
               ((s1_bytes_ff != '0) && (prod_bin_ff >= PB_W'(s1_bytes_ff)));
      out_data_in.looks_binary  = binary;
      out_data_in.sampled_lines = lines_sat;
      priority if (binary) begin
         out_data_in.format_code = FMT_UNKNOWN;
      end else if (s1_nonblank_ff == '0) begin
         out_data_in.format_code = FMT_PLAIN;
      end else if (prod_json_ff >= PJ_W'(s1_nonblank_ff)) begin
         out_data_in.format_code = FMT_JSON;
      end else begin
         out_data_in.format_code = FMT_PLAIN;
      end
   end

   assign s1_valid_in  = s1_ready ? !snap_empty : s1_valid_ff;
   assign out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_factor_ff  <= BINARY_DENSITY_RESET;
         json_factor_ff <= JSON_SHARE_RESET;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         bin_factor_ff  <= bin_factor_in;
         json_factor_ff <= json_factor_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_pop) begin
         prod_bin_ff    <= prod_bin_in;
         prod_json_ff   <= prod_json_in;
         s1_bytes_ff    <= snap.byte_total;
         s1_nonblank_ff <= snap.nonblank_count;
         s1_lines_ff    <= snap.line_count;
         s1_nul_ff      <= snap.nul_seen;
      end
      if (out_ready && s1_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire
